FILE: rtl/core/wfps_pkg.sv
// Shared types and constants for the watermark-fair producer selector.
`default_nettype none

package wfps_pkg;

    localparam int SLOTS        = 16;
    localparam int IDX_W        = $clog2(SLOTS);
    localparam int TIME_W       = 64;
    localparam int SLOT_FIELD_W = 4;

    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_NOTE   = 2'd1,
        FUNC_SELECT = 2'd2
    } func_t;

    typedef logic [IDX_W-1:0] idx_t;

    // status write into one cell
    typedef struct packed {
        logic              present;
        logic              queued;
        logic              inactive;
        logic              timed;
        logic [TIME_W-1:0] head_time;
    } slot_upd_t;

    // status bits a cell reports back for the start check
    typedef struct packed {
        logic present;
        logic queued;
        logic inactive;
    } slot_stat_t;

    typedef struct packed {
        logic found;
        idx_t idx;
    } hit_t;

    // what travels from cell to cell along the row
    typedef struct packed {
        logic seen_present;
        hit_t catch_hi;
        hit_t catch_all;
        hit_t drain_hi;
        hit_t drain_all;
    } chain_t;

    // common control broadcast to every cell
    typedef struct packed {
        logic              use_start;
        logic [TIME_W-1:0] watermark;
    } sel_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/wfps_cell.sv
// One producer slot: holds its status and joins the priority search chain.
`default_nettype none

module wfps_cell
    import wfps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire slot_upd_t  upd,
    input  wire sel_ctl_t   ctl,
    input  wire logic       ge_start,
    input  wire logic       gt_start,
    input  wire idx_t       cell_idx,
    input  wire chain_t     chain_in,
    output chain_t          chain_out,
    output slot_stat_t      stat
);

    logic              present_reg;
    logic              queued_reg;
    logic              inactive_reg;
    logic              timed_reg;
    logic [TIME_W-1:0] time_reg;

    logic catch_up;
    logic drain_ok;
    logic ge_q;
    logic gt_q;

    function automatic hit_t take(hit_t h, logic cond, idx_t i);
        hit_t r;
        r = h;
        if (!h.found && cond)
        begin
            r.found = 1'b1;
            r.idx   = i;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= 1'b0;
            queued_reg   <= 1'b0;
            inactive_reg <= 1'b0;
            timed_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            present_reg  <= upd.present;
            queued_reg   <= upd.queued;
            inactive_reg <= upd.inactive;
            timed_reg    <= upd.timed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_reg <= upd.head_time;
        end
    end

    always_comb
    begin
        catch_up = present_reg && queued_reg &&
                   (!timed_reg || ($signed(time_reg) < $signed(ctl.watermark)));
        drain_ok = present_reg && queued_reg;
        // without a usable start the walk begins at the lowest present slot
        ge_q = ctl.use_start ? ge_start : 1'b1;
        gt_q = ctl.use_start ? gt_start : chain_in.seen_present;

        chain_out.seen_present = chain_in.seen_present | present_reg;
        chain_out.catch_hi     = take(chain_in.catch_hi,  catch_up && ge_q, cell_idx);
        chain_out.catch_all    = take(chain_in.catch_all, catch_up,         cell_idx);
        chain_out.drain_hi     = take(chain_in.drain_hi,  drain_ok && gt_q, cell_idx);
        chain_out.drain_all    = take(chain_in.drain_all, drain_ok,         cell_idx);

        stat.present  = present_reg;
        stat.queued   = queued_reg;
        stat.inactive = inactive_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/watermark_fair_producer_select.sv
// Top level of the watermark-fair producer selector.
`default_nettype none

// Each beat is first registered from the input; then the row of slot cells runs its
// rotating search (or applies the status or watermark update) and loads the output
// register. A new beat is taken while a result waits; the compute step stalls only
// while the output register is still full. All functions cost the same. Function 0
// writes one slot cell, function 1 raises the watermark, function 2 picks a producer:
// first a queued slot from the start on (wrapping) with an untimed head or one older
// than the watermark, else the next queued slot after the start, also wrapping.
module watermark_fair_producer_select
    import wfps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // slot[3:0], present[4], queued[5], inactive[6], item_has_time[7],
    // item_time[71:8], start_valid[72], start_slot[76:73], zero fill
    input  wire logic [79:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // found[0], chosen_slot[4:1], drain_phase[5], start_cleared[6],
    // watermark[70:7], zero fill
    output logic [71:0]      m_tdata
);

    logic                    busy_reg;
    logic [1:0]              func_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic                    present_reg;
    logic                    queued_reg;
    logic                    inactive_reg;
    logic                    has_time_reg;
    logic [TIME_W-1:0]       time_reg;
    logic                    start_valid_reg;
    logic [SLOT_FIELD_W-1:0] start_slot_reg;

    logic                    out_valid_reg;
    logic [71:0]             out_data_reg;
    logic [TIME_W-1:0]       watermark_reg;
    logic [TIME_W-1:0]       watermark_next;

    logic       in_beat;
    logic       fire;
    logic       slot_in_range;
    logic       start_in_range;
    idx_t       slot_idx;
    idx_t       start_idx;
    slot_upd_t  upd;
    sel_ctl_t   ctl;
    slot_stat_t start_stat;
    logic       use_start;

    logic [SLOTS-1:0] wr_en;
    logic [SLOTS-1:0] ge_start;
    logic [SLOTS-1:0] gt_start;
    slot_stat_t       stat [SLOTS];
    chain_t           chain [SLOTS+1];
    chain_t           chain_end;

    logic                    found;
    idx_t                    chosen;
    logic                    drain;
    logic                    cleared;

    assign s_tready = !busy_reg;
    assign in_beat  = s_tvalid && !busy_reg;
    assign fire     = busy_reg && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            watermark_reg <= '0;
        end
        else
        begin
            if (in_beat)
            begin
                busy_reg <= 1'b1;
            end
            else if (fire)
            begin
                busy_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                watermark_reg <= watermark_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            func_reg        <= s_tuser;
            slot_reg        <= s_tdata[3:0];
            present_reg     <= s_tdata[4];
            queued_reg      <= s_tdata[5];
            inactive_reg    <= s_tdata[6];
            has_time_reg    <= s_tdata[7];
            time_reg        <= s_tdata[71:8];
            start_valid_reg <= s_tdata[72];
            start_slot_reg  <= s_tdata[76:73];
        end
        if (fire)
        begin
            out_data_reg <= {1'b0, watermark_next, cleared, drain,
                             SLOT_FIELD_W'(chosen), found};
        end
    end

    always_comb
    begin
        slot_in_range  = 32'(slot_reg) < SLOTS;
        start_in_range = 32'(start_slot_reg) < SLOTS;
        slot_idx       = IDX_W'(slot_reg);
        start_idx      = IDX_W'(start_slot_reg);

        upd.present   = present_reg;
        upd.queued    = queued_reg;
        upd.inactive  = inactive_reg;
        upd.timed     = has_time_reg;
        upd.head_time = time_reg;

        for (int i = 0; i < SLOTS; i++)
        begin
            wr_en[i]    = fire && (func_reg == FUNC_UPDATE) && slot_in_range &&
                          (slot_idx == IDX_W'(i));
            ge_start[i] = IDX_W'(i) >= start_idx;
            gt_start[i] = IDX_W'(i) > start_idx;
        end

        // a retired start is present, inactive and has nothing queued
        start_stat = stat[start_idx];
        use_start  = start_valid_reg && start_in_range && start_stat.present &&
                     !(start_stat.inactive && !start_stat.queued);

        ctl.use_start = use_start;
        ctl.watermark = watermark_reg;
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        wfps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (wr_en[g]),
            .upd      (upd),
            .ctl      (ctl),
            .ge_start (ge_start[g]),
            .gt_start (gt_start[g]),
            .cell_idx (IDX_W'(g)),
            .chain_in (chain[g]),
            .chain_out(chain[g+1]),
            .stat     (stat[g])
        );
    end

    assign chain_end = chain[SLOTS];

    always_comb
    begin
        found          = 1'b0;
        chosen         = '0;
        drain          = 1'b0;
        cleared        = 1'b0;
        watermark_next = watermark_reg;

        case (func_reg)
            FUNC_NOTE:
            begin
                if (has_time_reg && ($signed(watermark_reg) < $signed(time_reg)))
                begin
                    watermark_next = time_reg;
                end
            end
            FUNC_SELECT:
            begin
                if (chain_end.seen_present)
                begin
                    cleared = start_valid_reg && !use_start;
                    if (chain_end.catch_hi.found)
                    begin
                        found  = 1'b1;
                        chosen = chain_end.catch_hi.idx;
                    end
                    else if (chain_end.catch_all.found)
                    begin
                        found  = 1'b1;
                        chosen = chain_end.catch_all.idx;
                    end
                    else if (chain_end.drain_hi.found)
                    begin
                        found  = 1'b1;
                        chosen = chain_end.drain_hi.idx;
                        drain  = 1'b1;
                    end
                    else if (chain_end.drain_all.found)
                    begin
                        found  = 1'b1;
                        chosen = chain_end.drain_all.idx;
                        drain  = 1'b1;
                    end
                end
            end
            default:
            begin
                found = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
